FILE: rtl/assert_macros.svh
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
	else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
	else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

FILE: rtl/vdir_pkg.sv
`default_nettype none
package vdir_pkg;
	localparam int unsigned MaxVertices    = 1024;
	localparam int unsigned WordsPerVertex = 4;

	localparam logic [1:0] ReqWord  = 2'd0;
	localparam logic [1:0] ReqIndex = 2'd1;
	localparam logic [1:0] ReqStart = 2'd2;

	localparam logic [1:0] KindKept  = 2'd0;
	localparam logic [1:0] KindDup   = 2'd1;
	localparam logic [1:0] KindRemap = 2'd2;
	localparam logic [1:0] KindError = 2'd3;

	localparam logic [1:0] ErrNone  = 2'd0;
	localparam logic [1:0] ErrFull  = 2'd1;
	localparam logic [1:0] ErrRange = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEARCH_RD,
		ST_SEARCH_CMP,
		ST_STORE,
		ST_EMIT,
		ST_DUP,
		ST_FULL,
		ST_IDX_RD,
		ST_IDX_OUT,
		ST_RANGE
	} state_t;

	typedef struct packed {
		logic take_word;
		logic start;
		logic clr_pending;
		logic clr_search;
		logic rd_store;
		logic step_search;
		logic wr_store;
		logic wr_remap_dup;
		logic wr_remap_new;
		logic rd_remap;
		logic emit_kept;
		logic emit_dup;
		logic emit_full;
		logic emit_remap;
		logic emit_range;
		logic commit_new;
	} cmd_t;

	typedef struct packed {
		logic vertex_done;
		logic table_full;
		logic search_end;
		logic word_match;
		logic vert_match;
		logic word_last;
		logic idx_ok;
		logic out_busy;
	} sts_t;
endpackage
`default_nettype wire

FILE: rtl/vdir_ram.sv
`default_nettype none
module vdir_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

FILE: rtl/vdir_ctrl.sv
`default_nettype none
module vdir_ctrl (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_fire,
	input  wire logic [1:0]  req,
	input  wire vdir_pkg::sts_t sts,
	output logic             in_ready,
	output vdir_pkg::cmd_t   cmd
);
	vdir_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vdir_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vdir_pkg::ST_IDLE: begin
				if (in_fire) begin
					if (req == vdir_pkg::ReqWord && sts.vertex_done) begin
						state_d = sts.table_full ? vdir_pkg::ST_FULL : vdir_pkg::ST_SEARCH_RD;
					end else if (req == vdir_pkg::ReqIndex) begin
						state_d = sts.idx_ok ? vdir_pkg::ST_IDX_RD : vdir_pkg::ST_RANGE;
					end
				end
			end
			vdir_pkg::ST_SEARCH_RD: begin
				state_d = sts.search_end ? vdir_pkg::ST_STORE : vdir_pkg::ST_SEARCH_CMP;
			end
			vdir_pkg::ST_SEARCH_CMP: begin
				if (sts.word_match && sts.word_last) begin
					state_d = vdir_pkg::ST_DUP;
				end else begin
					state_d = vdir_pkg::ST_SEARCH_RD;
				end
			end
			vdir_pkg::ST_STORE: state_d = vdir_pkg::ST_EMIT;
			vdir_pkg::ST_EMIT: begin
				if (!sts.out_busy && sts.word_last) begin
					state_d = vdir_pkg::ST_IDLE;
				end
			end
			vdir_pkg::ST_DUP, vdir_pkg::ST_FULL, vdir_pkg::ST_RANGE, vdir_pkg::ST_IDX_OUT: begin
				if (!sts.out_busy) begin
					state_d = vdir_pkg::ST_IDLE;
				end
			end
			vdir_pkg::ST_IDX_RD: state_d = vdir_pkg::ST_IDX_OUT;
			default: state_d = vdir_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			vdir_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_fire) begin
					cmd.take_word   = (req == vdir_pkg::ReqWord);
					cmd.start       = (req == vdir_pkg::ReqStart);
					cmd.clr_search  = 1'b1;
					cmd.rd_remap    = (req == vdir_pkg::ReqIndex);
				end
			end
			vdir_pkg::ST_SEARCH_RD: begin
				cmd.rd_store = !sts.search_end;
			end
			vdir_pkg::ST_SEARCH_CMP: begin
				cmd.step_search = 1'b1;
			end
			vdir_pkg::ST_STORE: begin
				cmd.clr_search = 1'b1;
				cmd.wr_remap_new = 1'b1;
			end
			vdir_pkg::ST_EMIT: begin
				if (!sts.out_busy) begin
					cmd.emit_kept = 1'b1;
					cmd.wr_store  = 1'b1;
					if (sts.word_last) begin
						cmd.commit_new  = 1'b1;
						cmd.clr_pending = 1'b1;
					end
				end
			end
			vdir_pkg::ST_DUP: begin
				if (!sts.out_busy) begin
					cmd.emit_dup     = 1'b1;
					cmd.wr_remap_dup = 1'b1;
					cmd.clr_pending  = 1'b1;
				end
			end
			vdir_pkg::ST_FULL: begin
				if (!sts.out_busy) begin
					cmd.emit_full   = 1'b1;
					cmd.clr_pending = 1'b1;
				end
			end
			vdir_pkg::ST_IDX_OUT: cmd.emit_remap = !sts.out_busy;
			vdir_pkg::ST_RANGE:   cmd.emit_range = !sts.out_busy;
			vdir_pkg::ST_IDX_RD:  cmd.rd_remap = 1'b0;
			default: cmd = '0;
		endcase
	end
endmodule
`default_nettype wire

FILE: rtl/vdir_dp.sv
`default_nettype none
module vdir_dp #(
	parameter int unsigned MaxVertices    = vdir_pkg::MaxVertices,
	parameter int unsigned WordsPerVertex = vdir_pkg::WordsPerVertex
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire vdir_pkg::cmd_t cmd,
	input  wire logic [63:0] data_word,
	input  wire logic [15:0] index_value,
	input  wire logic        last_item,
	output vdir_pkg::sts_t   sts,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       out_kind,
	output logic [63:0]      out_word,
	output logic [9:0]       compact_index,
	output logic [10:0]      unique_total,
	output logic [1:0]       error_code,
	output logic             list_end,
	output logic             run_last
);
	localparam int unsigned VW = $clog2(MaxVertices);
	localparam int unsigned CW = $clog2(MaxVertices + 1);
	localparam int unsigned WW = (WordsPerVertex > 1) ? $clog2(WordsPerVertex) : 1;
	localparam int unsigned PW = $clog2(WordsPerVertex + 1);
	localparam int unsigned SD = MaxVertices * WordsPerVertex;
	localparam int unsigned SW = $clog2(SD);

	logic [63:0] pend_q [WordsPerVertex];
	logic [PW-1:0] wpos_q;
	logic [CW-1:0] loaded_q, uniq_q;
	logic [VW-1:0] srch_q;
	logic [WW-1:0] wsel_q;
	logic          match_q;
	logic          idx_last_q;
	logic [VW-1:0] idx_q;

	logic [PW-1:0] wpos_next;
	logic [VW-1:0] uniq_idx;
	logic [63:0]   s_rdata;
	logic [VW-1:0] r_rdata;
	logic [VW-1:0] r_waddr;
	logic          r_we;
	logic [VW-1:0] r_wdata;
	logic [63:0]   pend_sel;

	assign wpos_next = wpos_q + 1'b1;
	assign uniq_idx  = uniq_q[VW-1:0];
	assign pend_sel  = pend_q[wsel_q];

	logic [SW-1:0] s_raddr, s_waddr;
	if (WordsPerVertex > 1) begin : g_addr
		always_comb begin
			s_raddr = SW'(srch_q) * SW'(WordsPerVertex) + SW'(wsel_q);
			s_waddr = SW'(uniq_idx) * SW'(WordsPerVertex) + SW'(wsel_q);
		end
	end else begin : g_addr1
		always_comb begin
			s_raddr = SW'(srch_q);
			s_waddr = SW'(uniq_idx);
		end
	end

	vdir_ram #(.Width(64), .Depth(SD)) u_store (
		.clk(clk), .we(cmd.wr_store), .waddr(s_waddr), .wdata(pend_sel),
		.raddr(s_raddr), .rdata(s_rdata)
	);

	assign r_we    = cmd.wr_remap_dup | cmd.wr_remap_new;
	assign r_waddr = loaded_q[VW-1:0];
	assign r_wdata = cmd.wr_remap_dup ? srch_q : uniq_idx;

	// read address held for the whole lookup so a stalled result keeps its value
	vdir_ram #(.Width(VW), .Depth(MaxVertices)) u_remap (
		.clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
		.raddr(idx_q), .rdata(r_rdata)
	);

	always_comb begin
		sts = '0;
		sts.vertex_done = last_item || (wpos_next >= PW'(WordsPerVertex));
		sts.table_full  = (loaded_q == CW'(MaxVertices));
		sts.search_end  = ({1'b0, srch_q} >= {1'b0, uniq_q}) && !match_q;
		sts.word_match  = (s_rdata == pend_sel);
		sts.vert_match  = match_q;
		sts.word_last   = (wsel_q == WW'(WordsPerVertex - 1));
		sts.idx_ok      = (17'(index_value) < 17'(loaded_q));
		sts.out_busy    = out_valid && !out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q   <= '0;
			loaded_q <= '0;
			uniq_q   <= '0;
			srch_q   <= '0;
			wsel_q   <= '0;
			match_q  <= 1'b0;
			out_valid <= 1'b0;
			for (int i = 0; i < WordsPerVertex; i++) pend_q[i] <= '0;
		end else begin
			if (cmd.start || cmd.clr_pending) begin
				for (int i = 0; i < WordsPerVertex; i++) pend_q[i] <= '0;
				wpos_q <= '0;
			end
			if (cmd.start) begin
				loaded_q <= '0;
				uniq_q   <= '0;
			end
			if (cmd.take_word) begin
				pend_q[wpos_q[WW-1:0]] <= data_word;
				wpos_q <= wpos_next;
			end
			if (cmd.clr_search) begin
				srch_q <= '0;
				wsel_q <= '0;
				match_q <= 1'b0;
			end
			if (cmd.rd_store) match_q <= 1'b0;
			if (cmd.step_search) begin
				if (sts.word_match && !sts.word_last) begin
					wsel_q <= wsel_q + 1'b1;
				end else if (!sts.word_match) begin
					wsel_q <= '0;
					srch_q <= srch_q + 1'b1;
				end
			end
			if (cmd.wr_store && !sts.word_last) wsel_q <= wsel_q + 1'b1;
			if (cmd.wr_remap_dup || cmd.wr_remap_new) loaded_q <= loaded_q + 1'b1;
			if (cmd.commit_new) uniq_q <= uniq_q + 1'b1;
			if (cmd.emit_kept || cmd.emit_dup || cmd.emit_full || cmd.emit_remap
					|| cmd.emit_range) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_remap) begin
			idx_last_q <= last_item;
			idx_q <= index_value[VW-1:0];
		end
		if (cmd.emit_kept) begin
			out_kind <= vdir_pkg::KindKept;
			out_word <= pend_sel;
			compact_index <= 10'(uniq_idx);
			// every word of a kept vertex already counts it
			unique_total <= 11'(uniq_q) + 11'd1;
			error_code <= vdir_pkg::ErrNone;
			list_end <= 1'b0;
			run_last <= sts.word_last;
		end else if (cmd.emit_dup) begin
			out_kind <= vdir_pkg::KindDup;
			out_word <= '0;
			compact_index <= 10'(srch_q);
			unique_total <= 11'(uniq_q);
			error_code <= vdir_pkg::ErrNone;
			list_end <= 1'b0;
			run_last <= 1'b1;
		end else if (cmd.emit_full) begin
			out_kind <= vdir_pkg::KindError;
			out_word <= '0;
			compact_index <= '0;
			unique_total <= 11'(uniq_q);
			error_code <= vdir_pkg::ErrFull;
			list_end <= 1'b0;
			run_last <= 1'b1;
		end else if (cmd.emit_remap || cmd.emit_range) begin
			out_kind <= cmd.emit_remap ? vdir_pkg::KindRemap : vdir_pkg::KindError;
			out_word <= '0;
			compact_index <= cmd.emit_remap ? 10'(r_rdata) : 10'd0;
			unique_total <= 11'(uniq_q);
			error_code <= cmd.emit_remap ? vdir_pkg::ErrNone : vdir_pkg::ErrRange;
			list_end <= idx_last_q;
			run_last <= 1'b1;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/vertex_dedup_index_remap.sv
// channel | group  | payload (low bit first)
// in      | s_axis | tdata: data_word[63:0], index_value[79:64]; tuser: req_type; tlast: last_item
// out     | m_axis | tdata: out_word, compact_index, unique_total, error_code; tuser: out_kind;
//         |        | tlast: run_last, list_end in m_axis_tuser[2]
// an index request reads the remap table, then emits; a non-final vertex word is only stored
// a completed vertex reads and compares stored unique vertex words in turn (store read port)
// then writes its remap entry and emits and stores its words one by one
// reset: arst_n clears counts and pending vertex; stores are undefined until written
// stalls: results wait in the output register; input is held off until the item is done
`default_nettype none
`include "assert_macros.svh"
module vertex_dedup_index_remap #(
	parameter int unsigned MaxVertices    = vdir_pkg::MaxVertices,
	parameter int unsigned WordsPerVertex = vdir_pkg::WordsPerVertex
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [79:0]  s_axis_tdata,  // data_word, index_value
	input  wire logic [1:0]   s_axis_tuser,  // req_type
	input  wire logic         s_axis_tlast,  // last_item
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [87:0]       m_axis_tdata,  // out_word, compact_index, unique_total, error_code
	output logic [2:0]        m_axis_tuser,  // out_kind, list_end
	output logic              m_axis_tlast   // run_last
);
	vdir_pkg::cmd_t cmd;
	vdir_pkg::sts_t sts;
	logic in_fire;
	logic [1:0]  out_kind, error_code;
	logic [63:0] out_word;
	logic [9:0]  compact_index;
	logic [10:0] unique_total;
	logic        list_end;

	// input accepted only when controller is idle
	assign in_fire = s_axis_tvalid && s_axis_tready;

	vdir_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .req(s_axis_tuser),
		.sts(sts), .in_ready(s_axis_tready), .cmd(cmd)
	);

	vdir_dp #(.MaxVertices(MaxVertices), .WordsPerVertex(WordsPerVertex)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.data_word(s_axis_tdata[63:0]), .index_value(s_axis_tdata[79:64]),
		.last_item(s_axis_tlast), .sts(sts),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_kind(out_kind), .out_word(out_word), .compact_index(compact_index),
		.unique_total(unique_total), .error_code(error_code), .list_end(list_end),
		.run_last(m_axis_tlast)
	);

	// pack result beat
	assign m_axis_tdata = {1'b0, error_code, unique_total, compact_index, out_word};
	assign m_axis_tuser = {list_end, out_kind};

	`ASSERT_NEXT(a_busy_holds, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	`ASSERT_IMPLIES(a_kept_word_zero_err, clk, arst_n, m_axis_tvalid && out_kind == vdir_pkg::KindKept, error_code == vdir_pkg::ErrNone)
	`ASSERT_IMPLIES(a_error_has_code, clk, arst_n, m_axis_tvalid && out_kind == vdir_pkg::KindError, error_code != vdir_pkg::ErrNone)
endmodule
`default_nettype wire

FILE: bench/vdir_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module vdir_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [79:0] s_axis_tdata,  // data_word, index_value
	input  wire logic [1:0]  s_axis_tuser,  // req_type
	input  wire logic        s_axis_tlast,  // last_item
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [87:0] m_axis_tdata,  // out_word, compact_index, unique_total, error_code
	input  wire logic [2:0]  m_axis_tuser,  // out_kind, list_end
	input  wire logic        m_axis_tlast,  // run_last
	output int               mismatches,
	output int               outstanding
);
	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] word;
		logic [9:0]  cidx;
		logic [10:0] total;
		logic [1:0]  err;
		logic        lend;
		logic        last;
	} vdir_result_t;

	vdir_result_t predicted_results[$];

	logic [63:0] kept_words[vdir_pkg::MaxVertices*vdir_pkg::WordsPerVertex];
	logic [9:0]  first_seen[vdir_pkg::MaxVertices];
	logic [63:0] assembling[vdir_pkg::WordsPerVertex];
	int          word_pos;
	int          loaded;
	int          uniques;

	initial begin
		mismatches  = 0;
		outstanding = 0;
		word_pos    = 0;
		loaded      = 0;
		uniques     = 0;
		for (int i = 0; i < vdir_pkg::WordsPerVertex; i++) assembling[i] = '0;
	end

	function automatic void push_result(logic [1:0] kind, logic [63:0] word,
		logic [9:0] cidx, logic [1:0] err, logic lend, logic last);
		vdir_result_t r;
		r.kind  = kind;
		r.word  = word;
		r.cidx  = cidx;
		r.total = uniques[10:0];
		r.err   = err;
		r.lend  = lend;
		r.last  = last;
		predicted_results.push_back(r);
	endfunction

	function automatic void drop_pending();
		for (int i = 0; i < vdir_pkg::WordsPerVertex; i++) assembling[i] = '0;
		word_pos = 0;
	endfunction

	// full-table check, then bit-exact search of the kept vertices, then store or flag as duplicate
	function automatic void weld_vertex();
		bit same;
		if (loaded >= vdir_pkg::MaxVertices) begin
			drop_pending();
			push_result(vdir_pkg::KindError, '0, '0, vdir_pkg::ErrFull, 1'b0, 1'b1);
			return;
		end
		for (int k = 0; k < uniques; k++) begin
			same = 1;
			for (int w = 0; w < vdir_pkg::WordsPerVertex; w++)
				if (kept_words[k*vdir_pkg::WordsPerVertex+w] !== assembling[w]) same = 0;
			if (same) begin
				first_seen[loaded] = k[9:0];
				loaded++;
				drop_pending();
				push_result(vdir_pkg::KindDup, '0, k[9:0], vdir_pkg::ErrNone, 1'b0, 1'b1);
				return;
			end
		end
		for (int w = 0; w < vdir_pkg::WordsPerVertex; w++)
			kept_words[uniques*vdir_pkg::WordsPerVertex+w] = assembling[w];
		first_seen[loaded] = uniques[9:0];
		loaded++;
		uniques++;
		for (int w = 0; w < vdir_pkg::WordsPerVertex; w++)
			push_result(vdir_pkg::KindKept, assembling[w], 10'(uniques - 1),
				vdir_pkg::ErrNone, 1'b0, w == vdir_pkg::WordsPerVertex - 1);
		drop_pending();
	endfunction

	function automatic void predict_beat(logic [1:0] req, logic [63:0] word,
		logic [15:0] idx, logic last);
		case (req)
			vdir_pkg::ReqWord: begin
				if (word_pos < vdir_pkg::WordsPerVertex) assembling[word_pos] = word;
				word_pos++;
				if (last || word_pos >= vdir_pkg::WordsPerVertex) weld_vertex();
			end
			vdir_pkg::ReqIndex: begin
				if (idx < loaded)
					push_result(vdir_pkg::KindRemap, '0, first_seen[idx], vdir_pkg::ErrNone,
						last, 1'b1);
				else
					push_result(vdir_pkg::KindError, '0, '0, vdir_pkg::ErrRange, last, 1'b1);
			end
			vdir_pkg::ReqStart: begin
				drop_pending();
				loaded  = 0;
				uniques = 0;
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk) begin
		vdir_result_t got, want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				predict_beat(s_axis_tuser, s_axis_tdata[63:0], s_axis_tdata[79:64],
					s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				got.kind  = m_axis_tuser[1:0];
				got.word  = m_axis_tdata[63:0];
				got.cidx  = m_axis_tdata[73:64];
				got.total = m_axis_tdata[84:74];
				got.err   = m_axis_tdata[86:85];
				got.lend  = m_axis_tuser[2];
				got.last  = m_axis_tlast;
				if (predicted_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected output beat kind=%0d word=%h cidx=%0d",
							got.kind, got.word, got.cidx);
				end else begin
					want = predicted_results.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: exp kind=%0d word=%h cidx=%0d total=%0d ",
								"err=%0d lend=%0d last=%0d | got kind=%0d word=%h cidx=%0d ",
								"total=%0d err=%0d lend=%0d last=%0d"},
								want.kind, want.word, want.cidx, want.total, want.err,
								want.lend, want.last, got.kind, got.word, got.cidx,
								got.total, got.err, got.lend, got.last);
					end
				end
			end
		end
		outstanding = predicted_results.size();
	end
endmodule
`default_nettype wire

FILE: bench/tb_vertex_dedup_index_remap.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_vertex_dedup_index_remap;
	// no-handshake cycles before giving up; the worst search reads every stored word of a full table
	localparam int StallLimit = 40000;
	localparam int HoldCycles = 300;
	// request type the block ignores
	localparam logic [1:0] ReqUnused = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata;  // data_word, index_value
	logic [1:0]  s_axis_tuser;  // req_type
	logic        s_axis_tlast;  // last_item
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [87:0] m_axis_tdata;  // out_word, compact_index, unique_total, error_code
	logic [2:0]  m_axis_tuser;  // out_kind, list_end
	logic        m_axis_tlast;  // run_last

	int mismatches;
	int outstanding;

	// idle mode: 0 sender light / receiver heavy, 1 swapped, 2 no idling
	int idle_mode;
	bit hold_go;
	int hold_left;
	int quiet_cycles;

	// a handful of vertices reused so duplicates turn up often
	logic [63:0] vertex_pool[6][vdir_pkg::WordsPerVertex];

	vertex_dedup_index_remap dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	vdir_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// receiver: random stalls by mode, or a long hold-off on request
	initial m_axis_tready = 1'b0;
	always @(negedge clk) begin
		if (hold_go) begin
			hold_go   = 0;
			hold_left = HoldCycles;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= $urandom_range(99) >=
				((idle_mode == 0) ? 76 : (idle_mode == 1) ? 10 : 0);
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else if (arst_n)
			quiet_cycles++;
		if (quiet_cycles >= StallLimit) begin
			$display("vertex_dedup_index_remap verification failed");
			$finish;
		end
	end

	// called just after a falling edge; returns just after the next falling edge
	// following acceptance, leaving tvalid high for a back-to-back beat
	task automatic send_beat(logic [1:0] req, logic [63:0] word, logic [15:0] idx,
		logic last);
		while ($urandom_range(99) < ((idle_mode == 0) ? 10 : (idle_mode == 1) ? 76 : 0)) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= req;
		s_axis_tdata  <= {idx, word};
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	// words 0..n-1 of a pool entry; last set on word n-1 (random if n is full)
	task automatic send_vertex(int sel, int n);
		for (int w = 0; w < n; w++)
			send_beat(vdir_pkg::ReqWord, vertex_pool[sel][w], 16'($urandom),
				(w == n - 1) ? ((n < vdir_pkg::WordsPerVertex) ? 1'b1 : 1'($urandom)) : 1'b0);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	initial begin
		int sel, n, r;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = vdir_pkg::ReqStart;
		s_axis_tlast  = 1'b0;
		idle_mode     = 0;
		hold_go       = 0;
		hold_left     = 0;
		quiet_cycles  = 0;
		for (int p = 0; p < 6; p++)
			for (int w = 0; w < vdir_pkg::WordsPerVertex; w++)
				vertex_pool[p][w] = {$urandom, $urandom};
		for (int w = 0; w < vdir_pkg::WordsPerVertex; w++) begin
			vertex_pool[0][w] = '0;
			vertex_pool[1][w] = '1;
		end
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty-table lookups, extremes, duplicates, short vertices
		send_beat(vdir_pkg::ReqIndex, '0, 16'h0000, 1'b0);
		send_beat(vdir_pkg::ReqIndex, '0, 16'hffff, 1'b1);
		send_vertex(0, vdir_pkg::WordsPerVertex);
		send_vertex(1, vdir_pkg::WordsPerVertex);
		send_vertex(0, vdir_pkg::WordsPerVertex);
		send_vertex(2, 1);                      // early last, rest zero
		send_vertex(2, 2);
		send_beat(vdir_pkg::ReqWord, vertex_pool[3][0], '0, 1'b0);
		send_beat(vdir_pkg::ReqIndex, '0, 16'd2, 1'b0);   // lookup mid-vertex
		send_beat(ReqUnused, '1, '1, 1'b1);     // unused request, ignored
		send_beat(vdir_pkg::ReqWord, vertex_pool[3][1], '0, 1'b1);
		for (int i = 0; i < 7; i++)
			send_beat(vdir_pkg::ReqIndex, '0, i[15:0], i == 6);
		send_beat(vdir_pkg::ReqWord, vertex_pool[4][0], '0, 1'b0);
		send_beat(vdir_pkg::ReqStart, '0, '0, 1'b0);      // discards the partial vertex
		send_beat(vdir_pkg::ReqIndex, '0, 16'd0, 1'b1);
		drain();

		// long receiver hold-off while the sender keeps offering beats
		hold_go = 1;
		for (int i = 0; i < 12; i++) send_vertex(i % 6, vdir_pkg::WordsPerVertex);
		drain();

		// random: mostly vertices from the pool, whole or short, some fresh, plus lookups
		for (int phase = 0; phase < 3; phase++) begin
			idle_mode = phase;
			for (int i = 0; i < 25; i++) begin
				r = $urandom_range(99);
				if (r < 55) begin
					sel = $urandom_range(5);
					n   = $urandom_range(vdir_pkg::WordsPerVertex, 1);
					if (r < 12)
						for (int w = 0; w < vdir_pkg::WordsPerVertex; w++)
							vertex_pool[sel][w] = {$urandom, $urandom};
					send_vertex(sel, n);
				end else if (r < 85) begin
					send_beat(vdir_pkg::ReqIndex, {$urandom, $urandom},
						($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(40)),
						1'($urandom));
				end else if (r < 90) begin
					send_beat(vdir_pkg::ReqStart, {$urandom, $urandom}, 16'($urandom),
						1'($urandom));
				end else if (r < 95) begin
					send_beat(ReqUnused, {$urandom, $urandom}, 16'($urandom), 1'($urandom));
				end else begin
					send_beat(vdir_pkg::ReqWord, {$urandom, $urandom}, 16'($urandom), 1'b0);
				end
			end
			drain();
		end

		drain();
		repeat (100) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("vertex_dedup_index_remap verification clean");
		else
			$display("vertex_dedup_index_remap verification failed");
		$finish;
	end
endmodule
`default_nettype wire

FILE: vertex_dedup_index_remap.f
+incdir+rtl
rtl/vdir_pkg.sv
rtl/vdir_ram.sv
rtl/vdir_ctrl.sv
rtl/vdir_dp.sv
rtl/vertex_dedup_index_remap.sv
bench/vdir_checker.sv
bench/tb_vertex_dedup_index_remap.sv
